[hdl/mtbm_pkg.sv]
// Shared types, register indexes and helpers for the button mode controller.
package mtbm_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TAP_MIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_MIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COUNT = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [15:0] TAP_MIN_RST      = 16'd100;
    localparam logic [15:0] ACK_MIN_RST      = 16'd1000;
    localparam logic [15:0] MUTE_MIN_RST     = 16'd3000;
    localparam logic [15:0] QUIET_RST        = 16'd800;
    localparam logic [15:0] ROTATE_RST       = 16'd5000;
    localparam logic [4:0]  SCREEN_COUNT_RST = 5'd7;

    // Largest usable screen count.
    localparam logic [4:0] SCREEN_MAX = 5'd16;

    // Tap counter saturation value.
    localparam logic [1:0] TAPS_MAX = 2'd3;

    // Operating modes.
    typedef enum logic [1:0] {
        MODE_STD    = 2'd0,
        MODE_HIGH   = 2'd1,
        MODE_HIDDEN = 2'd2
    } mode_t;

    // One input transaction.
    typedef struct packed {
        logic        button_down;
        logic [31:0] now_ms;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic [1:0] op_mode;
        logic [3:0] screen_index;
        logic       redraw;
        logic       mute_pulse;
        logic       ack_pulse;
        logic       mode_changed;
        logic       blank_display;
        logic       resume_link;
    } result_t;

    // Current configuration, as seen by the decoder.
    typedef struct packed {
        logic [15:0] tap_min_ms;
        logic [15:0] ack_min_ms;
        logic [15:0] mute_min_ms;
        logic [15:0] quiet_ms;
        logic [15:0] rotate_ms;
        logic [4:0]  screen_count;
    } cfg_t;

    // Next screen index; the count is clamped to 1..16 and the index wraps to 0.
    function automatic logic [3:0] next_screen(input logic [3:0] s, input logic [4:0] count);
        logic [4:0] n;
        logic [3:0] inc;
        logic [3:0] res;
        n = count;
        if (n == 5'd0)
        begin
            n = 5'd1;
        end
        if (n > SCREEN_MAX)
        begin
            n = SCREEN_MAX;
        end
        inc = s + 4'd1;
        res = inc;
        if (inc == 4'd0 || {1'b0, inc} >= n)
        begin
            res = 4'd0;
        end
        return res;
    endfunction

endpackage

[hdl/multi_tap_button_mode_controller.sv]
// Top level of the multi-tap and long-press button mode controller.
//
//   Channel   Ports                                   Payload
//   item      item_valid, item_stall, item            button_down, now_ms
//   result    result_valid, result_stall, result      op_mode .. resume_link
//   config    cfg_write, cfg_index, cfg_data          six 16/5-bit registers
//
// One poll per clock cycle is sustained while result_stall is low: the decoder state updates in the
// same cycle in which the held poll moves into the result register.
// result_valid rises once the accepted item has passed the input register and been loaded
// into the result register; the result is taken in a cycle with result_stall low.
// Reset clears the decoder state, loads the register defaults and empties both stages.
// A stalled result holds the held poll, which in turn stalls the item side.
module multi_tap_button_mode_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  mtbm_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output mtbm_pkg::result_t               result,
    input  logic                            cfg_write,
    input  logic [mtbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mtbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mtbm_pkg::*;

    cfg_t    cfg;
    logic    held_valid;
    item_t   held_item;
    logic    out_free;
    logic    fire;
    result_t core_result;

    // A held poll is processed whenever the result register can take it.
    assign fire = held_valid && out_free;

    mtbm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mtbm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .take       (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    mtbm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (held_item),
        .cfg    (cfg),
        .result (core_result)
    );

    mtbm_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .data         (core_result),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[hdl/mtbm_cfg.sv]
// Configuration register file for the button mode controller.
module mtbm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [mtbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mtbm_pkg::CFG_DATA_W-1:0] cfg_data,
    output mtbm_pkg::cfg_t                 cfg
);
    import mtbm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_TAP_MIN:      cfg_next.tap_min_ms   = cfg_data;
                REG_ACK_MIN:      cfg_next.ack_min_ms   = cfg_data;
                REG_MUTE_MIN:     cfg_next.mute_min_ms  = cfg_data;
                REG_QUIET:        cfg_next.quiet_ms     = cfg_data;
                REG_ROTATE:       cfg_next.rotate_ms    = cfg_data;
                REG_SCREEN_COUNT: cfg_next.screen_count = cfg_data[4:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tap_min_ms   <= TAP_MIN_RST;
            cfg_reg.ack_min_ms   <= ACK_MIN_RST;
            cfg_reg.mute_min_ms  <= MUTE_MIN_RST;
            cfg_reg.quiet_ms     <= QUIET_RST;
            cfg_reg.rotate_ms    <= ROTATE_RST;
            cfg_reg.screen_count <= SCREEN_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/mtbm_in_stage.sv]
// Input register that holds one transaction until the decoder takes it.
module mtbm_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  mtbm_pkg::item_t item,
    input  logic            take,
    output logic            held_valid,
    output mtbm_pkg::item_t held_item
);
    import mtbm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // The register is free when empty or when its content leaves this cycle.
    assign item_stall = valid_reg && !take;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[hdl/mtbm_core.sv]
// Button decoder state and the single-pass logic that turns one poll into one result.
module mtbm_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  mtbm_pkg::item_t   item,
    input  mtbm_pkg::cfg_t    cfg,
    output mtbm_pkg::result_t result
);
    import mtbm_pkg::*;

    // Decoder state.
    logic        was_down_reg,     was_down_next;
    logic [31:0] press_start_reg,  press_start_next;
    logic [1:0]  tap_count_reg,    tap_count_next;
    logic [31:0] release_time_reg, release_time_next;
    mode_t       mode_reg,         mode_next;
    logic [3:0]  screen_reg,       screen_next;
    logic [31:0] advance_time_reg, advance_time_next;

    // Intermediate terms.
    logic        down;
    logic [31:0] now;
    logic [31:0] held;
    logic [31:0] since_release;
    logic [31:0] since_advance;
    logic        release_edge;
    logic        hold_mute;
    logic        hold_ack;
    logic        tap_hit;
    logic [1:0]  taps_mid;
    logic        quiet_ok;
    logic        group_fires;
    mode_t       target;
    logic        tap_advance;
    logic        auto_advance;
    logic        mode_change;

    assign down          = item.button_down;
    assign now           = item.now_ms;
    assign held          = now - press_start_reg;
    assign since_release = now - release_time_reg;
    assign since_advance = now - advance_time_reg;
    assign release_edge  = !down && was_down_reg;

    // Hold classification at release, checked in the order mute, acknowledge, tap.
    assign hold_mute = release_edge && (held >= {16'd0, cfg.mute_min_ms});
    assign hold_ack  = release_edge && !hold_mute && (held >= {16'd0, cfg.ack_min_ms});
    assign tap_hit   = release_edge && !hold_mute && !hold_ack
                       && (held >= {16'd0, cfg.tap_min_ms});

    // Tap count after the release is handled.
    always_comb
    begin
        taps_mid = tap_count_reg;
        if (hold_mute || hold_ack)
        begin
            taps_mid = 2'd0;
        end
        else if (tap_hit && tap_count_reg != TAPS_MAX)
        begin
            taps_mid = tap_count_reg + 2'd1;
        end
    end

    // A tap in this poll sets the release time to now, so the gap is zero.
    assign quiet_ok    = tap_hit ? (cfg.quiet_ms == 16'd0)
                                 : (since_release >= {16'd0, cfg.quiet_ms});
    assign group_fires = (taps_mid != 2'd0) && !down && quiet_ok;

    // Mode the tap group asks for.
    always_comb
    begin
        target = mode_reg;
        case (taps_mid)
            2'd2:    target = (mode_reg == MODE_HIGH) ? MODE_STD : MODE_HIGH;
            2'd3:    target = (mode_reg == MODE_HIDDEN) ? MODE_STD : MODE_HIDDEN;
            default: target = mode_reg;
        endcase
    end

    assign mode_change = group_fires && (target != mode_reg);
    assign tap_advance = group_fires && (taps_mid == 2'd1) && (mode_reg != MODE_HIDDEN);

    // A tap advance resets the advance time to now, which rules out an auto advance.
    assign auto_advance = !tap_advance && (mode_reg != MODE_HIDDEN)
                          && (since_advance > {16'd0, cfg.rotate_ms});

    // Next state.
    always_comb
    begin
        was_down_next     = down;
        press_start_next  = (down && !was_down_reg) ? now : press_start_reg;
        release_time_next = tap_hit ? now : release_time_reg;
        tap_count_next    = group_fires ? 2'd0 : taps_mid;
        mode_next         = mode_change ? target : mode_reg;
        screen_next       = screen_reg;
        advance_time_next = advance_time_reg;
        if (tap_advance || auto_advance)
        begin
            screen_next       = next_screen(screen_reg, cfg.screen_count);
            advance_time_next = now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_down_reg     <= 1'b0;
            press_start_reg  <= 32'd0;
            tap_count_reg    <= 2'd0;
            release_time_reg <= 32'd0;
            mode_reg         <= MODE_STD;
            screen_reg       <= 4'd0;
            advance_time_reg <= 32'd0;
        end
        else if (fire)
        begin
            was_down_reg     <= was_down_next;
            press_start_reg  <= press_start_next;
            tap_count_reg    <= tap_count_next;
            release_time_reg <= release_time_next;
            mode_reg         <= mode_next;
            screen_reg       <= screen_next;
            advance_time_reg <= advance_time_next;
        end
    end

    // Result fields for this poll.
    always_comb
    begin
        result.op_mode       = mode_next;
        result.screen_index  = screen_next;
        result.redraw        = tap_advance || auto_advance || mode_change;
        result.mute_pulse    = hold_mute;
        result.ack_pulse     = hold_ack;
        result.mode_changed  = mode_change;
        result.blank_display = mode_change && (target == MODE_HIDDEN);
        result.resume_link   = mode_change && (mode_reg == MODE_HIDDEN);
    end

endmodule

[hdl/mtbm_out_stage.sv]
// Result register that holds one transaction until the receiver takes it.
module mtbm_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mtbm_pkg::result_t data,
    output logic              free,
    output logic              result_valid,
    input  logic              result_stall,
    output mtbm_pkg::result_t result
);
    import mtbm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can load when empty or when its content leaves this cycle.
    assign free = !valid_reg || !result_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule
